[src/cls_pkg.sv]
`default_nettype none

package cls_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;
    localparam int DATA_W = 32;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // broadcast to every cell of the row
    typedef struct packed {
        logic                     do_remove;
        logic                     do_append;
        logic [IDX_W-1:0]         index;
        logic [IDX_W-1:0]         tail;
        logic signed [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage

`default_nettype wire

[src/cls_cmd_if.sv]
`default_nettype none

interface cls_cmd_if;
    logic                                      valid;
    logic                                      ready;
    logic [1:0]                                cmd;
    logic [cls_pkg::IDX_W-1:0]                 index;
    logic signed [cls_pkg::DATA_W-1:0]         value;

    modport source (output valid, output cmd, output index, output value, input ready);
    modport sink   (input valid, input cmd, input index, input value, output ready);
endinterface

`default_nettype wire

[src/cls_rsp_if.sv]
`default_nettype none

interface cls_rsp_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [cls_pkg::DATA_W-1:0]         read_value;
    logic [1:0]                                status;
    logic [cls_pkg::CNT_W-1:0]                 count;
    logic [cls_pkg::CNT_W-1:0]                 allocated;

    modport source (output valid, output read_value, output status, output count,
                    output allocated, input ready);
    modport sink   (input valid, input read_value, input status, input count,
                    input allocated, output ready);
endinterface

`default_nettype wire

[src/compacting_list_store.sv]
// compacting_list_store
// Ordered list of signed 32-bit values held in a row of DEPTH storage cells.
// Command channel (req): cmd, index, value. Response channel (rsp): read_value,
// status, count, allocated. Both are valid/ready; a beat moves when both are high.
// Append writes the cell at the tail; remove makes every cell at or above the
// index load its upper neighbour in the same cycle; read ORs together the cell
// taps selected by the index. The response is registered and appears in the
// cycle after the command beat.
// Throughput is one command per cycle while rsp.ready is held high; the whole
// row updates in the accepting cycle, so nothing further limits it.
// A bad index on a remove or read gives status range and leaves the list
// untouched; an append with DEPTH entries held gives status full and is dropped.
// allocated follows 0, 1, 2, 4, ... saturating at DEPTH, growing on an append
// that finds count equal to allocated.
// Reset (rst_n low, asynchronous) empties the list, clears allocated and drops
// any pending response; cell contents are left as they are.
// When rsp stalls, the pending response holds and req.ready falls until it is
// taken.
`default_nettype none

module compacting_list_store (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cls_cmd_if.sink    req,
    cls_rsp_if.source  rsp
);

    localparam logic [cls_pkg::CNT_W-1:0] DEPTH_C = cls_pkg::CNT_W'(cls_pkg::DEPTH);

    logic [cls_pkg::CNT_W-1:0] count_reg, count_next;
    logic [cls_pkg::CNT_W-1:0] cap_reg, cap_next;
    logic                      rsp_valid_reg;
    logic signed [cls_pkg::DATA_W-1:0] rd_reg, rd_next;
    logic [1:0]                status_reg, status_next;

    logic                      accept;
    logic                      in_range;
    logic                      full;
    logic [cls_pkg::CNT_W:0]   cap_grow;
    cls_pkg::cell_ctl_t        ctl;
    logic signed [cls_pkg::DATA_W-1:0] tap_or;

    logic signed [cls_pkg::DATA_W-1:0] cell_data [cls_pkg::DEPTH];
    logic signed [cls_pkg::DATA_W-1:0] cell_tap  [cls_pkg::DEPTH];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign in_range  = {1'b0, req.index} < count_reg;
    assign full      = count_reg >= DEPTH_C;

    always_comb
    begin
        cap_grow = (cap_reg == '0) ? (cls_pkg::CNT_W+1)'(1) : {cap_reg, 1'b0};
        if (cap_grow > {1'b0, DEPTH_C})
        begin
            cap_grow = {1'b0, DEPTH_C};
        end
    end

    always_comb
    begin
        ctl.do_remove = accept && (req.cmd == cls_pkg::CMD_REMOVE) && in_range;
        ctl.do_append = accept && (req.cmd == cls_pkg::CMD_APPEND) && !full;
        ctl.index     = req.index;
        ctl.tail      = count_reg[cls_pkg::IDX_W-1:0];
        ctl.value     = req.value;
    end

    genvar g;
    generate
        for (g = 0; g < cls_pkg::DEPTH; g++)
        begin : g_cell
            logic signed [cls_pkg::DATA_W-1:0] upper;
            if (g == cls_pkg::DEPTH - 1)
            begin : g_top
                assign upper = '0;
            end
            else
            begin : g_mid
                assign upper = cell_data[g+1];
            end
            cls_cell u_cell (
                .clk   (clk),
                .pos   (cls_pkg::IDX_W'(g)),
                .ctl   (ctl),
                .upper (upper),
                .data  (cell_data[g]),
                .tap   (cell_tap[g])
            );
        end
    endgenerate

    always_comb
    begin
        tap_or = '0;
        for (int i = 0; i < cls_pkg::DEPTH; i++)
        begin
            tap_or = tap_or | cell_tap[i];
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        cap_next    = cap_reg;
        rd_next     = '0;
        status_next = cls_pkg::ST_OK;
        unique case (req.cmd)
            cls_pkg::CMD_APPEND:
            begin
                if (full)
                begin
                    status_next = cls_pkg::ST_FULL;
                end
                else
                begin
                    if (count_reg == cap_reg)
                    begin
                        cap_next = cap_grow[cls_pkg::CNT_W-1:0];
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            cls_pkg::CMD_REMOVE:
            begin
                if (!in_range)
                begin
                    status_next = cls_pkg::ST_RANGE;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            cls_pkg::CMD_READ:
            begin
                if (!in_range)
                begin
                    status_next = cls_pkg::ST_RANGE;
                end
                else
                begin
                    rd_next = tap_or;
                end
            end
            default:
            begin
                // unused code: no operation
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                cap_reg       <= cap_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg     <= rd_next;
            status_reg <= status_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_value = rd_reg;
    assign rsp.status     = status_reg;
    assign rsp.count      = count_reg;
    assign rsp.allocated  = cap_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count beyond store depth");

    a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("entry count exceeds allocated capacity");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.cmd == cls_pkg::CMD_APPEND) && !full)
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("append did not advance the count");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.cmd == cls_pkg::CMD_REMOVE) && in_range)
        |=> (count_reg == $past(count_reg) - 1'b1) && (status_reg == cls_pkg::ST_OK))
        else $error("remove did not shrink the count");

endmodule

`default_nettype wire

[src/cls_cell.sv]
`default_nettype none

module cls_cell (
    input  wire logic                                  clk,
    input  wire logic [cls_pkg::IDX_W-1:0]             pos,
    input  wire cls_pkg::cell_ctl_t                    ctl,
    input  wire logic signed [cls_pkg::DATA_W-1:0]     upper,
    output logic signed [cls_pkg::DATA_W-1:0]          data,
    output logic signed [cls_pkg::DATA_W-1:0]          tap
);

    logic signed [cls_pkg::DATA_W-1:0] data_reg;
    logic signed [cls_pkg::DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        // remove: every cell at or above the hole takes its upper neighbour
        if (ctl.do_remove && (pos >= ctl.index))
        begin
            data_next = upper;
        end
        if (ctl.do_append && (pos == ctl.tail))
        begin
            data_next = ctl.value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = (pos == ctl.index) ? data_reg : '0;

endmodule

`default_nettype wire

[tb/tb_compacting_list_store.sv]
`timescale 1ns / 1ps

module tb_compacting_list_store;

    localparam logic [1:0] CMD_SPARE = 2'd3;  // unused code, behaves as a no-op
    localparam int N_DIRECTED = 19;
    localparam int N_RANDOM   = 1880;
    localparam int LONG_HOLD  = 90;
    localparam int TAIL_WAIT  = 6;

    typedef struct packed {
        logic signed [cls_pkg::DATA_W-1:0] read_value;
        logic [1:0]                        status;
        logic [cls_pkg::CNT_W-1:0]         count;
        logic [cls_pkg::CNT_W-1:0]         allocated;
    } list_rsp_t;

    typedef struct packed {
        logic [1:0]                        cmd;
        logic [cls_pkg::IDX_W-1:0]         index;
        logic signed [cls_pkg::DATA_W-1:0] value;
        logic                              fixed;   // rsp typed in below rather than predicted
        list_rsp_t                         rsp;
    } list_beat_t;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_FILL, MIX_NOISE, MIX_PROBE} mix_t;

    logic clk;
    logic rst_n;

    cls_cmd_if req_if ();
    cls_rsp_if rsp_if ();

    compacting_list_store u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // shadow copy of the list
    logic signed [cls_pkg::DATA_W-1:0] list_vals [cls_pkg::DEPTH];
    int                                list_len;
    int                                list_cap;

    list_rsp_t pending_rsps [$];
    int        mismatches;

    // typed expectation of the beat currently offered
    logic      cur_fixed;
    list_rsp_t cur_rsp;
    int        burst_left;

    list_beat_t dir_beats [N_DIRECTED] = '{
        '{cls_pkg::CMD_READ, 6'd0, 32'sd0, 1'b1,
          '{32'sd0, cls_pkg::ST_RANGE, 7'd0, 7'd0}},
        '{cls_pkg::CMD_REMOVE, 6'd63, 32'sd0, 1'b1,
          '{32'sd0, cls_pkg::ST_RANGE, 7'd0, 7'd0}},
        '{CMD_SPARE, 6'd63, 32'shFFFF_FFFF, 1'b1,
          '{32'sd0, cls_pkg::ST_OK, 7'd0, 7'd0}},
        '{cls_pkg::CMD_APPEND, 6'd0, 32'sh8000_0000, 1'b1,
          '{32'sd0, cls_pkg::ST_OK, 7'd1, 7'd1}},
        '{cls_pkg::CMD_APPEND, 6'd63, 32'sh7FFF_FFFF, 1'b1,
          '{32'sd0, cls_pkg::ST_OK, 7'd2, 7'd2}},
        '{cls_pkg::CMD_APPEND, 6'd21, 32'shFFFF_FFFF, 1'b1,
          '{32'sd0, cls_pkg::ST_OK, 7'd3, 7'd4}},
        '{cls_pkg::CMD_READ, 6'd0, 32'sd0, 1'b1,
          '{32'sh8000_0000, cls_pkg::ST_OK, 7'd3, 7'd4}},
        '{cls_pkg::CMD_READ, 6'd2, 32'sh1234_5678, 1'b1,
          '{32'shFFFF_FFFF, cls_pkg::ST_OK, 7'd3, 7'd4}},
        '{cls_pkg::CMD_READ, 6'd3, 32'sd0, 1'b1,
          '{32'sd0, cls_pkg::ST_RANGE, 7'd3, 7'd4}},
        '{cls_pkg::CMD_READ, 6'd63, 32'sd0, 1'b1,
          '{32'sd0, cls_pkg::ST_RANGE, 7'd3, 7'd4}},
        '{cls_pkg::CMD_APPEND, 6'd63, 32'sd0, 1'b1,
          '{32'sd0, cls_pkg::ST_OK, 7'd4, 7'd4}},
        '{cls_pkg::CMD_APPEND, 6'd42, 32'sh5A5A_A5A5, 1'b1,
          '{32'sd0, cls_pkg::ST_OK, 7'd5, 7'd8}},
        '{cls_pkg::CMD_REMOVE, 6'd0, 32'sd0, 1'b0, '0},
        '{cls_pkg::CMD_READ, 6'd0, 32'sd0, 1'b0, '0},
        '{cls_pkg::CMD_REMOVE, 6'd3, 32'sd0, 1'b0, '0},
        '{cls_pkg::CMD_REMOVE, 6'd3, 32'sd0, 1'b1,
          '{32'sd0, cls_pkg::ST_RANGE, 7'd3, 7'd8}},
        '{cls_pkg::CMD_READ, 6'd2, 32'sd0, 1'b0, '0},
        '{cls_pkg::CMD_REMOVE, 6'd1, 32'sd0, 1'b0, '0},
        '{cls_pkg::CMD_READ, 6'd1, 32'sd0, 1'b0, '0}
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic list_rsp_t apply_list_cmd(logic [1:0] op,
                                                 logic [cls_pkg::IDX_W-1:0] at,
                                                 logic signed [cls_pkg::DATA_W-1:0] val);
        list_rsp_t r;
        int        k;
        r        = '0;
        r.status = cls_pkg::ST_OK;
        case (op)
            cls_pkg::CMD_APPEND:
            begin
                if (list_len >= cls_pkg::DEPTH)
                begin
                    r.status = cls_pkg::ST_FULL;
                end
                else
                begin
                    if (list_len == list_cap)
                    begin
                        list_cap = (list_cap == 0) ? 1 : list_cap * 2;
                        if (list_cap > cls_pkg::DEPTH)
                        begin
                            list_cap = cls_pkg::DEPTH;
                        end
                    end
                    list_vals[list_len] = val;
                    list_len++;
                end
            end
            cls_pkg::CMD_REMOVE:
            begin
                if (int'(at) >= list_len)
                begin
                    r.status = cls_pkg::ST_RANGE;
                end
                else
                begin
                    for (k = int'(at); k < list_len - 1; k++)
                    begin
                        list_vals[k] = list_vals[k + 1];
                    end
                    list_len--;
                end
            end
            cls_pkg::CMD_READ:
            begin
                if (int'(at) >= list_len)
                begin
                    r.status = cls_pkg::ST_RANGE;
                end
                else
                begin
                    r.read_value = list_vals[at];
                end
            end
            default:
            begin
            end
        endcase
        r.count     = cls_pkg::CNT_W'(list_len);
        r.allocated = cls_pkg::CNT_W'(list_cap);
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic offer_beat(list_beat_t b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
        end
        cur_fixed     = b.fixed;
        cur_rsp       = b.rsp;
        req_if.valid <= 1'b1;
        req_if.cmd   <= b.cmd;
        req_if.index <= b.index;
        req_if.value <= b.value;
        do
        begin
            @(posedge clk);
        end
        while (!req_if.ready);
        @(negedge clk);
        burst_left--;
    endtask

    // response checker and predictor
    always @(posedge clk)
    begin : monitor
        list_rsp_t want;
        list_rsp_t got;
        list_rsp_t pred;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got = '{rsp_if.read_value, rsp_if.status, rsp_if.count, rsp_if.allocated};
                if (pending_rsps.size() == 0)
                begin
                    $display("%0t: response beat with nothing outstanding: %p", $time, got);
                    mismatches++;
                end
                else
                begin
                    want = pending_rsps.pop_front();
                    if (got.read_value !== want.read_value)
                    begin
                        $display("%0t: read_value expected %0d got %0d",
                                 $time, want.read_value, got.read_value);
                        mismatches++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, got.status);
                        mismatches++;
                    end
                    if (got.count !== want.count)
                    begin
                        $display("%0t: count expected %0d got %0d",
                                 $time, want.count, got.count);
                        mismatches++;
                    end
                    if (got.allocated !== want.allocated)
                    begin
                        $display("%0t: allocated expected %0d got %0d",
                                 $time, want.allocated, got.allocated);
                        mismatches++;
                    end
                end
            end
            if (req_if.valid && req_if.ready)
            begin
                pred = apply_list_cmd(req_if.cmd, req_if.index, req_if.value);
                pending_rsps.push_back(cur_fixed ? cur_rsp : pred);
            end
        end
    end

    // response side: stall patterns, plus one long hold-off to back the block up
    initial
    begin : rsp_stall
        int cyc;
        int hold_from;
        int style;
        int style_left;
        rsp_if.ready = 1'b0;
        cyc          = 0;
        style_left   = 0;
        style        = 0;
        hold_from    = $urandom_range(400, 1500);
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (style_left == 0)
            begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(16, 160);
            end
            style_left--;
            if (cyc >= hold_from && cyc < hold_from + LONG_HOLD)
            begin
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                case (style)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= 1'($urandom_range(0, 1));
                    2: rsp_if.ready <= ($urandom_range(0, 3) != 0);
                    default: rsp_if.ready <= ((cyc % 5) < 2);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        list_beat_t b;
        mix_t       mix;
        int         sent;
        int         mix_left;
        int         pick;
        clk          = 1'b0;
        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.cmd   = cls_pkg::CMD_APPEND;
        req_if.index = '0;
        req_if.value = '0;
        cur_fixed    = 1'b0;
        cur_rsp      = '0;
        burst_left   = 0;
        list_len     = 0;
        list_cap     = 0;
        mismatches   = 0;
        sent         = 0;
        mix_left     = 0;
        mix          = MIX_GROW;
        foreach (list_vals[i])
        begin
            list_vals[i] = '0;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_beats[i])
        begin
            offer_beat(dir_beats[i]);
        end

        while (sent < N_RANDOM)
        begin
            if (mix_left == 0)
            begin
                pick = $urandom_range(0, 9);
                mix  = (pick < 4) ? MIX_GROW : (pick < 6) ? MIX_SHRINK :
                       (pick == 6) ? MIX_FILL : (pick == 7) ? MIX_NOISE : MIX_PROBE;
                // a fill runs past the top so that appends hit a full store
                mix_left = (mix == MIX_FILL) ? cls_pkg::DEPTH - list_len + $urandom_range(1, 4)
                                             : $urandom_range(10, 80);
            end
            mix_left--;
            pick = $urandom_range(0, 99);
            case (mix)
                MIX_GROW:   b.cmd = (pick < 60) ? cls_pkg::CMD_APPEND :
                                    (pick < 80) ? cls_pkg::CMD_READ : cls_pkg::CMD_REMOVE;
                MIX_SHRINK: b.cmd = (pick < 20) ? cls_pkg::CMD_APPEND :
                                    (pick < 50) ? cls_pkg::CMD_READ : cls_pkg::CMD_REMOVE;
                MIX_FILL:   b.cmd = cls_pkg::CMD_APPEND;
                MIX_PROBE:  b.cmd = (pick < 10) ? cls_pkg::CMD_APPEND :
                                    (pick < 85) ? cls_pkg::CMD_READ : cls_pkg::CMD_REMOVE;
                default:    b.cmd = 2'($urandom_range(0, 3));
            endcase
            if (mix != MIX_NOISE && list_len > 0 && $urandom_range(0, 9) < 8)
            begin
                b.index = cls_pkg::IDX_W'($urandom_range(0, list_len - 1));
            end
            else
            begin
                b.index = cls_pkg::IDX_W'($urandom_range(0, cls_pkg::DEPTH - 1));
            end
            case ($urandom_range(0, 31))
                0:       b.value = 32'sh8000_0000;
                1:       b.value = 32'sh7FFF_FFFF;
                2:       b.value = 32'shFFFF_FFFF;
                3:       b.value = 32'sd0;
                default: b.value = $urandom;
            endcase
            b.fixed = 1'b0;
            b.rsp   = '0;
            offer_beat(b);
            sent++;
        end
        req_if.valid <= 1'b0;

        while (pending_rsps.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_WAIT) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
